/* hdl/tkt_pkg.sv */
// Package with the shared constants, payload structs and control structs of the top-K tracker.
package tkt_pkg;

	localparam int MAX_KEEP   = 64;
	localparam int VALUE_W    = 32;
	localparam int KEEP_W     = 7;
	localparam int HELD_W     = 7;
	localparam int COUNT_W    = $clog2(MAX_KEEP + 1);
	localparam int KEEP_EXT_W = (COUNT_W > KEEP_W) ? COUNT_W : KEEP_W;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(64);

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      start_set;
	} sample_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] smallest_kept;
		logic [HELD_W-1:0]         held_count;
	} result_t;

	typedef struct packed {
		logic                      valid;
		logic                      start;
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_W-1:0]        keep;
	} step_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] min_value;
		logic [COUNT_W-1:0]        count;
	} chain_status_t;

endpackage

/* hdl/streaming_top_k_tracker.sv */
// Top level of the streaming top-K tracker: config register, input stage, chain, result stage.
//
// This block keeps the K largest signed 32-bit samples of a stream and, for every sample
// transfer, delivers one result transfer with the smallest kept value (the K-th largest
// once K values are held) and the number of values held. K comes from the keep_count
// register, written through write_enable and write_data; the user must write it only while
// the block is idle, which the block does not enforce. Zero acts as one and values above
// MAX_KEEP saturate. Lowering K below the held count keeps the values already held and the
// store stays in replace mode until a start flag arrives. A sample with start_set high
// empties the store before it is placed. The block takes one sample per cycle while
// result_stall is low; each sample passes the input register, the chain and the result
// register. The kept values live in a sorted chain of MAX_KEEP cells; every cell compares
// with the new sample in parallel and shifts by at most one place in the same cycle. The
// store needs no clearing pass after reset; only cells below the held count are ever read.
module streaming_top_k_tracker import tkt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_enable,
	input  logic [KEEP_W-1:0] write_data,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	logic [KEEP_W-1:0]     keep_q;
	logic [KEEP_EXT_W-1:0] keep_ext;
	logic [KEEP_EXT_W-1:0] keep_sat;
	logic                  valid_s1;
	sample_t               data_s1;
	logic                  advance;
	step_t                 step;
	chain_status_t         status;

	// The keep_count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (write_enable) begin
			keep_q <= write_data;
		end
	end

	// Effective K: zero counts as one, anything above the chain length saturates.
	always_comb begin
		keep_ext = KEEP_EXT_W'(keep_q);
		keep_sat = keep_ext;
		if (keep_ext == '0) begin
			keep_sat = KEEP_EXT_W'(1);
		end else if (keep_ext > KEEP_EXT_W'(MAX_KEEP)) begin
			keep_sat = KEEP_EXT_W'(MAX_KEEP);
		end
	end

	tkt_in_reg u_in_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1)
	);

	// The chain moves only when the result register can take the outcome.
	assign step.valid = valid_s1 && advance;
	assign step.start = data_s1.start_set;
	assign step.value = data_s1.sample_value;
	assign step.keep  = COUNT_W'(keep_sat);

	tkt_sort_chain u_sort_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.status (status)
	);

	tkt_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.status       (status),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* hdl/tkt_in_reg.sv */
// Input register stage that holds one accepted sample until the chain takes it.
module tkt_in_reg import tkt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample,
	input  logic    advance,
	output logic    valid_s1,
	output sample_t data_s1
);

	logic take;

	assign take         = !valid_s1 || advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && sample_valid) begin
			data_s1 <= sample;
		end
	end

endmodule

/* hdl/tkt_sort_chain.sv */
// Sorted register chain that keeps the largest values in ascending order, minimum at cell zero.
module tkt_sort_chain import tkt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  step_t         step,
	output chain_status_t status
);

	logic signed [VALUE_W-1:0] cells_q [MAX_KEEP];
	logic [COUNT_W-1:0]        count_q;

	logic signed [VALUE_W-1:0] cell_nxt [MAX_KEEP];
	logic [MAX_KEEP-1:0]       cell_we;
	logic [MAX_KEEP-1:0]       held;
	logic [MAX_KEEP-1:0]       above;
	logic [MAX_KEEP-1:0]       below;
	logic [COUNT_W-1:0]        base_count;
	logic [COUNT_W-1:0]        count_nxt;
	logic                      full;

	// A start flag empties the store before the value is placed.
	assign base_count = step.start ? '0 : count_q;
	assign full       = base_count >= step.keep;
	assign count_nxt  = full ? base_count : base_count + COUNT_W'(1);

	for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_val;
		logic signed [VALUE_W-1:0] next_val;
		logic                      prev_above;
		logic                      next_below;

		// Empty cells count as larger than any value.
		assign held[g]  = COUNT_W'(g) < base_count;
		assign above[g] = !held[g] || (cells_q[g] > step.value);
		assign below[g] = held[g] && (cells_q[g] < step.value);

		if (g == 0) begin : g_first
			assign prev_val   = step.value;
			assign prev_above = 1'b0;
		end else begin : g_mid
			assign prev_val   = cells_q[g-1];
			assign prev_above = above[g-1];
		end

		if (g == MAX_KEEP - 1) begin : g_last
			assign next_val   = step.value;
			assign next_below = 1'b0;
		end else begin : g_inner
			assign next_val   = cells_q[g+1];
			assign next_below = below[g+1];
		end

		// Insert: larger entries move up one place to open a slot.
		// Replace: the minimum drops out and smaller entries move down.
		assign cell_we[g]  = full ? (held[g] && below[0]) : (COUNT_W'(g) <= base_count);
		assign cell_nxt[g] = full
			? (next_below ? next_val : (below[g] ? step.value : cells_q[g]))
			: (above[g] ? (prev_above ? prev_val : step.value) : cells_q[g]);
	end

	assign status.min_value = cell_we[0] ? cell_nxt[0] : cells_q[0];
	assign status.count     = count_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step.valid) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_KEEP; i++) begin
			if (step.valid && cell_we[i]) begin
				cells_q[i] <= cell_nxt[i];
			end
		end
	end

endmodule

/* hdl/tkt_out_reg.sv */
// Result register that holds one result until the downstream side takes it.
module tkt_out_reg import tkt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  chain_status_t status,
	output logic          advance,
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result
);

	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result.smallest_kept <= status.min_value;
			result.held_count    <= HELD_W'(status.count);
		end
	end

endmodule
